@@ sv/sbdt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sbdt_pkg: shared constants and types
// Sizes, character codes, the handoff record and the emitter states of the
// signed binary to decimal text converter.
// ----------------------------------------------------------------------------
package sbdt_pkg;

	// Width of the signed value taken from the input item (8 to 128)
	localparam int VALUE_BITS = 128;

	// Decimal digits needed for a magnitude of up to 2^(VALUE_BITS-1)
	localparam int DIGITS   = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int BCD_BITS = DIGITS * 4;
	localparam int CNT_W    = $clog2(VALUE_BITS);
	localparam int DIG_W    = $clog2(DIGITS);

	// Port widths
	localparam int FIELD_W    = 64;
	localparam int IN_DATA_W  = 2 * FIELD_W;
	localparam int CHAR_W     = 6;
	localparam int OUT_DATA_W = 8;

	// Character codes
	localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;
	localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;
	localparam logic [CHAR_W-1:0] CH_NINE  = 6'd57;

	// Converted value handed from the converter to the emitter
	typedef struct packed {
		logic                neg;
		logic [BCD_BITS-1:0] bcd;
	} conv_t;

	// Emitter states
	typedef enum logic [1:0] {
		EMIT_IDLE,
		EMIT_SIGN,
		EMIT_DIGIT
	} emit_state_t;

endpackage
`default_nettype wire

@@ sv/sbdt_dabble.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sbdt_dabble: bit-serial binary to BCD converter
// Shifts the magnitude in one bit per cycle, most significant first, and
// corrects every BCD digit before each shift (double dabble).
// ----------------------------------------------------------------------------
module sbdt_dabble (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             load,
	input  wire [sbdt_pkg::VALUE_BITS-1:0]  load_mag,
	input  wire                             load_neg,
	output logic                            ready,
	output logic                            conv_valid,
	input  wire                             conv_take,
	output sbdt_pkg::conv_t                 conv
);
	import sbdt_pkg::*;

	logic                  busy_q;
	logic                  full_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [VALUE_BITS-1:0] sh_q;
	logic [BCD_BITS-1:0]   bcd_q;
	logic                  neg_q;
	logic [BCD_BITS-1:0]   bcd_adj;

	// Add three to every digit of five or more
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	// Control: busy while shifting, full until the emitter takes the digits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			full_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(VALUE_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					full_q <= 1'b1;
				end
			end else if (full_q && conv_take) begin
				full_q <= 1'b0;
			end
		end
	end

	// Datapath: capture, then shift one bit into the BCD register per cycle
	always_ff @(posedge clk) begin
		if (load) begin
			sh_q  <= load_mag;
			bcd_q <= '0;
			neg_q <= load_neg;
		end else if (busy_q) begin
			sh_q  <= {sh_q[VALUE_BITS-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_BITS-2:0], sh_q[VALUE_BITS-1]};
		end
	end

	assign ready      = !busy_q && !full_q;
	assign conv_valid = full_q;
	assign conv.neg   = neg_q;
	assign conv.bcd   = bcd_q;

endmodule
`default_nettype wire

@@ sv/sbdt_emit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sbdt_emit: decimal text serializer
// Emits '-' for a negative value, then the BCD digits one per cycle from the
// top unless stalled, dropping leading zeros, via a registered output stage.
// ----------------------------------------------------------------------------
module sbdt_emit (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          conv_valid,
	output logic                         conv_take,
	input  sbdt_pkg::conv_t              conv,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [sbdt_pkg::CHAR_W-1:0]  out_char,
	output logic                         out_last
);
	import sbdt_pkg::*;

	emit_state_t         state_q;
	emit_state_t         state_d;
	logic [BCD_BITS-1:0] digs_q;
	logic [DIG_W-1:0]    dig_cnt_q;
	logic                seen_q;
	logic                out_valid_q;
	logic [CHAR_W-1:0]   out_char_q;
	logic                out_last_q;

	logic [3:0] top_dig;
	logic       is_last;
	logic       show;
	logic       out_free;
	logic       emit_sign;
	logic       dig_step;
	logic       dig_emit;

	// Step decisions for the current digit slot
	always_comb begin
		top_dig   = digs_q[BCD_BITS-1 -: 4];
		is_last   = (dig_cnt_q == '0);
		show      = (top_dig != 4'd0) || seen_q || is_last;
		out_free  = !out_valid_q || out_ready;
		conv_take = (state_q == EMIT_IDLE) && conv_valid;
		emit_sign = (state_q == EMIT_SIGN) && out_free;
		dig_step  = (state_q == EMIT_DIGIT) && (!show || out_free);
		dig_emit  = dig_step && show;
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			EMIT_IDLE: begin
				if (conv_valid) begin
					state_d = conv.neg ? EMIT_SIGN : EMIT_DIGIT;
				end
			end
			EMIT_SIGN: begin
				if (out_free) begin
					state_d = EMIT_DIGIT;
				end
			end
			EMIT_DIGIT: begin
				if (dig_step && is_last) begin
					state_d = EMIT_IDLE;
				end
			end
			default: begin
				state_d = EMIT_IDLE;
			end
		endcase
	end

	// State and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= EMIT_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit_sign || dig_emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Digit register: load on handoff, advance one digit per step
	always_ff @(posedge clk) begin
		if (conv_take) begin
			digs_q    <= conv.bcd;
			dig_cnt_q <= DIG_W'(DIGITS - 1);
			seen_q    <= 1'b0;
		end else if (dig_step) begin
			digs_q    <= {digs_q[BCD_BITS-5:0], 4'd0};
			dig_cnt_q <= dig_cnt_q - 1'b1;
			if (show) begin
				seen_q <= 1'b1;
			end
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (emit_sign) begin
			out_char_q <= CH_MINUS;
			out_last_q <= 1'b0;
		end else if (dig_emit) begin
			out_char_q <= CH_ZERO + {2'b00, top_dig};
			out_last_q <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

endmodule
`default_nettype wire

@@ sv/signed_binary_to_decimal_text.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_text: signed integer to decimal ASCII text
//
// Input stream s_*: one item is a signed value, value_high in s_tdata[63:0]
// (two's complement, carries the sign) and value_low in s_tdata[127:64].
// Output stream m_*: one item per character, the ASCII code in
// m_tdata[5:0], m_tlast on the final character of each value. A negative
// value starts with '-', digits follow without leading zeros, zero gives '0'.
//
// The magnitude is formed in the accept cycle and shifted into a BCD register
// one bit per cycle. The emitter takes the digits when it is idle and walks
// all DIGITS (39) digit slots from the top, one per cycle while the output
// is not stalled, after a minus sign for a negative value. The converter
// takes the next item as soon as it has handed its digits over, so
// conversion overlaps emission.
// A stalled receiver holds the output register and the emitter; the next
// value waits in the converter, and s_tready stays low until it moves on.
// Reset empties both stages; no state carries from one item to the next.
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_text (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	// value_high [63:0], value_low [127:64]
	input  wire  [sbdt_pkg::IN_DATA_W-1:0]    s_tdata,
	output logic                              m_tvalid,
	input  wire                               m_tready,
	// char_code [5:0], zero fill [7:6]
	output logic [sbdt_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                              m_tlast
);
	import sbdt_pkg::*;

	logic [IN_DATA_W-1:0]  full_val;
	logic [VALUE_BITS-1:0] val;
	logic                  val_neg;
	logic [VALUE_BITS-1:0] val_mag;
	logic                  load;
	logic                  dab_ready;
	logic                  conv_valid;
	logic                  conv_take;
	conv_t                 conv;
	logic [CHAR_W-1:0]     out_char;

	// Reassemble the value, keep its low bits and take the magnitude
	always_comb begin
		full_val = {s_tdata[FIELD_W-1:0], s_tdata[IN_DATA_W-1:FIELD_W]};
		val      = full_val[VALUE_BITS-1:0];
		val_neg  = val[VALUE_BITS-1];
		val_mag  = val_neg ? (~val + 1'b1) : val;
	end

	assign s_tready = dab_ready;
	assign load     = s_tvalid && dab_ready;

	sbdt_dabble u_dabble (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.load_mag   (val_mag),
		.load_neg   (val_neg),
		.ready      (dab_ready),
		.conv_valid (conv_valid),
		.conv_take  (conv_take),
		.conv       (conv)
	);

	sbdt_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.conv_valid (conv_valid),
		.conv_take  (conv_take),
		.conv       (conv),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_char   (out_char),
		.out_last   (m_tlast)
	);

	assign m_tdata = {{(OUT_DATA_W - CHAR_W){1'b0}}, out_char};

	// Converter is busy right after it takes an item
	a_busy_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("converter ready right after accepting an item");

	// Only a minus sign or a digit leaves the block
	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[CHAR_W-1:0] == CH_MINUS) ||
			((m_tdata[CHAR_W-1:0] >= CH_ZERO) && (m_tdata[CHAR_W-1:0] <= CH_NINE)))
		else $error("illegal character code");

	// A minus sign is never the final character
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[CHAR_W-1:0] == CH_MINUS) |-> !m_tlast)
		else $error("minus sign flagged as last character");

endmodule
`default_nettype wire
